// ===== src/salru_pkg.sv =====
package salru_pkg;

    // Fixed field widths
    localparam int ADDR_W     = 32;
    localparam int TAG_W      = 32;
    localparam int AGE_W      = 32;
    localparam int WAY_OUT_W  = 3;
    localparam int OFF_W      = 4;
    localparam int IDX_W      = 3;
    localparam int CFG_WAYS_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    // Way count and way counter width; holds up to 16 ways
    localparam int WCNT_W     = 5;

    // Clamp for the configured offset width
    localparam logic [OFF_W-1:0] OFFSET_MAX = 4'd12;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    // Register reset values
    localparam logic [OFF_W-1:0]      OFFSET_BITS_RST = 4'd6;
    localparam logic [IDX_W-1:0]      INDEX_BITS_RST  = 3'd6;
    localparam logic [CFG_WAYS_W-1:0] WAYS_IN_USE_RST = 4'd8;

    // Access kinds
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_STORE = 1'b1;

    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] address;
    } req_t;

    typedef struct packed {
        logic                 hit;
        logic                 filled;
        logic [WAY_OUT_W-1:0] way_used;
    } rsp_t;

    // One way of a set as held in the tag memory
    typedef struct packed {
        logic             valid;
        logic [AGE_W-1:0] age;
        logic [TAG_W-1:0] tag;
    } entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_COMPARE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear;
        logic capture;
        logic mem_rd;
        logic compare;
        logic search;
        logic finish;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic need_search;
        logic search_last;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== src/set_assoc_cache_lru_tags.sv =====
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   in_data (req_t: func, address)
// out       output     out_valid / out_ready out_data (rsp_t: hit, filled, way_used)
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One access at a time: a hit or a store steps through accept, read, compare and
// write-back, with the result registered at the write-back; a load miss adds a
// victim search that scans the ways in use serially, stopping early at an invalid way;
// the single-port tag memory and the serial scan set this.
// After reset a clearing sweep writes every set with in_ready low; configuration
// beats are taken at any time.
// A held result does not block the next accept; the write-back waits for the
// output register to free up.
module set_assoc_cache_lru_tags
    import salru_pkg::*;
#(
    parameter int MAX_SETS_LOG2 = 6,
    parameter int WAYS          = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  req_t                  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rsp_t                  out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    salru_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    salru_dp #(
        .MAX_SETS_LOG2 (MAX_SETS_LOG2),
        .WAYS          (WAYS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // One access in flight: an accept closes the input until the access is done
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted twice in a row");

    // A hit never also reports a fill
    a_hit_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.hit && out_data.filled))
        else $error("hit and fill reported together");

    // A store miss reports way 0
    a_miss_way_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.hit && !out_data.filled) |-> (out_data.way_used == '0))
        else $error("store miss with nonzero way");

endmodule

// ===== src/salru_ctrl.sv =====
module salru_ctrl
    import salru_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output ctl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_COMPARE;
            end
            ST_COMPARE:
            begin
                state_next = stat.need_search ? ST_SEARCH : ST_FINISH;
            end
            ST_SEARCH:
            begin
                if (stat.search_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_READ:
            begin
                cmd.mem_rd = 1'b1;
            end
            ST_COMPARE:
            begin
                cmd.compare = 1'b1;
            end
            ST_SEARCH:
            begin
                cmd.search = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== src/salru_dp.sv =====
module salru_dp
    import salru_pkg::*;
#(
    parameter int MAX_SETS_LOG2 = 6,
    parameter int WAYS          = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctl_cmd_t              cmd,
    output dp_stat_t              stat,
    input  req_t                  in_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rsp_t                  out_data
);

    localparam int SET_W    = (MAX_SETS_LOG2 > 0) ? MAX_SETS_LOG2 : 1;
    localparam int NUM_ROWS = 1 << SET_W;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int IB_MAX_I = (MAX_SETS_LOG2 > 7) ? 7 : MAX_SETS_LOG2;
    localparam logic [IDX_W-1:0]  IB_MAX = IDX_W'(IB_MAX_I);
    localparam logic [WCNT_W-1:0] WAYS_C = WCNT_W'(WAYS);

    typedef entry_t [WAYS-1:0] row_t;

    // Tag memory: one row per set, all ways side by side
    row_t row_mem [NUM_ROWS];

    logic [OFF_W-1:0]      offset_bits_reg;
    logic [IDX_W-1:0]      index_bits_reg;
    logic [CFG_WAYS_W-1:0] ways_in_use_reg;

    logic [SET_W-1:0]  clr_cnt_reg;
    logic              func_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [SET_W-1:0]  set_reg;
    row_t              rd_data_reg;
    row_t              row_reg;
    logic              hit_reg;
    logic [WAY_W-1:0]  hit_way_reg;
    logic [WAY_W-1:0]  victim_reg;
    logic [AGE_W-1:0]  best_reg;
    logic [WCNT_W-1:0] way_cnt_reg;
    logic              out_valid_reg;
    rsp_t              out_reg;

    logic [OFF_W-1:0]  ob;
    logic [IDX_W-1:0]  ib;
    logic [WCNT_W-1:0] nw;
    logic [WCNT_W-1:0] ways_ext;
    logic [WCNT_W-1:0] sh_tag;
    logic [ADDR_W-1:0] addr_sh;
    logic [SET_W-1:0]  set_mask;

    row_t              aged_row;
    logic              hit_any;
    logic [WAY_W-1:0]  hit_way;

    entry_t            cur;
    logic [WAY_W-1:0]  cur_way;

    logic              fill;
    row_t              fin_row;
    row_t              clr_row;
    logic [WAY_W-1:0]  way_sel;
    rsp_t              rsp;

    logic              wr_en;
    logic [SET_W-1:0]  wr_addr;
    row_t              wr_row;

    // Effective configuration after clamping
    always_comb
    begin
        ob       = (offset_bits_reg > OFFSET_MAX) ? OFFSET_MAX : offset_bits_reg;
        ib       = (index_bits_reg > IB_MAX) ? IB_MAX : index_bits_reg;
        ways_ext = WCNT_W'(ways_in_use_reg);
        if (ways_ext == '0)
        begin
            nw = WCNT_W'(1);
        end
        else if (ways_ext > WAYS_C)
        begin
            nw = WAYS_C;
        end
        else
        begin
            nw = ways_ext;
        end
    end

    // Address split
    always_comb
    begin
        sh_tag   = WCNT_W'(ob) + WCNT_W'(ib);
        addr_sh  = in_data.address >> ob;
        set_mask = ~({SET_W{1'b1}} << ib);
    end

    // Aging and tag compare over the ways in use
    always_comb
    begin
        aged_row = rd_data_reg;
        hit_any  = 1'b0;
        hit_way  = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (WCNT_W'(w) < nw)
            begin
                if (aged_row[w].age != '1)
                begin
                    aged_row[w].age = aged_row[w].age + AGE_W'(1);
                end
                if (rd_data_reg[w].valid && (rd_data_reg[w].tag == tag_reg))
                begin
                    if (!hit_any)
                    begin
                        hit_way = WAY_W'(w);
                    end
                    hit_any         = 1'b1;
                    aged_row[w].age = '0;
                end
            end
        end
    end

    // Victim search, one way per cycle
    assign cur_way = way_cnt_reg[WAY_W-1:0];
    assign cur     = row_reg[cur_way];

    // Row write-back and result
    always_comb
    begin
        fill    = !hit_reg && (func_reg == FUNC_LOAD);
        fin_row = row_reg;
        if (fill)
        begin
            fin_row[victim_reg].valid = 1'b1;
            fin_row[victim_reg].age   = '0;
            fin_row[victim_reg].tag   = tag_reg;
        end
        if (hit_reg)
        begin
            way_sel = hit_way_reg;
        end
        else if (fill)
        begin
            way_sel = victim_reg;
        end
        else
        begin
            way_sel = '0;
        end
        rsp.hit      = hit_reg;
        rsp.filled   = fill;
        rsp.way_used = WAY_OUT_W'(way_sel);
        for (int w = 0; w < WAYS; w++)
        begin
            clr_row[w].valid = 1'b0;
            clr_row[w].age   = '0;
            clr_row[w].tag   = '1;
        end
    end

    // Memory port mux
    always_comb
    begin
        wr_en   = cmd.clear || cmd.finish;
        wr_addr = cmd.clear ? clr_cnt_reg : set_reg;
        wr_row  = cmd.clear ? clr_row : fin_row;
    end

    // Status
    always_comb
    begin
        stat.clear_last  = (clr_cnt_reg == '1);
        stat.need_search = !hit_any && (func_reg == FUNC_LOAD);
        stat.search_last = !cur.valid || ((way_cnt_reg + WCNT_W'(1)) == nw);
        stat.out_free    = !out_valid_reg || out_ready;
    end

    // Tag memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[wr_addr] <= wr_row;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= row_mem[set_reg];
        end
    end

    // Control state: configuration, clear sweep, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= OFFSET_BITS_RST;
            index_bits_reg  <= INDEX_BITS_RST;
            ways_in_use_reg <= WAYS_IN_USE_RST;
            clr_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_OFFSET_BITS: offset_bits_reg <= cfg_data[OFF_W-1:0];
                    CFG_INDEX_BITS:  index_bits_reg  <= cfg_data[IDX_W-1:0];
                    CFG_WAYS_IN_USE: ways_in_use_reg <= cfg_data[CFG_WAYS_W-1:0];
                    default:         ;
                endcase
            end
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= in_data.func;
            tag_reg  <= in_data.address >> sh_tag;
            set_reg  <= addr_sh[SET_W-1:0] & set_mask;
        end
        if (cmd.compare)
        begin
            row_reg     <= aged_row;
            hit_reg     <= hit_any;
            hit_way_reg <= hit_way;
            victim_reg  <= '0;
            best_reg    <= '0;
            way_cnt_reg <= '0;
        end
        if (cmd.search)
        begin
            way_cnt_reg <= way_cnt_reg + WCNT_W'(1);
            if (!cur.valid)
            begin
                victim_reg <= cur_way;
            end
            else if (cur.age > best_reg)
            begin
                best_reg   <= cur.age;
                victim_reg <= cur_way;
            end
        end
        if (cmd.finish)
        begin
            out_reg <= rsp;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
